### sv/krpd_pkg.sv
// ----------------------------------------------------------------------------
// krpd_pkg
// Types, widths and key decode tables for the keypad RGB PWM dimmer.
// ----------------------------------------------------------------------------
package krpd_pkg;

  localparam int LEVEL_W       = 7;
  localparam int KEY_W         = 4;
  localparam int STEP_W        = 4;
  localparam int PWM_SLOTS_DEF = 100;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [STEP_W-1:0]  step_t;

  localparam level_t LEVEL_MAX  = level_t'(100);
  localparam step_t  STEP_RESET = step_t'(1);

  typedef enum logic [1:0] {
    SEL_NONE  = 2'd0,
    SEL_RED   = 2'd1,
    SEL_GREEN = 2'd2,
    SEL_BLUE  = 2'd3
  } chan_sel_t;

  typedef enum logic [2:0] {
    ACT_LEVEL,
    ACT_PLUS,
    ACT_MINUS,
    ACT_SEL_RED,
    ACT_SEL_GREEN,
    ACT_SEL_BLUE,
    ACT_NONE
  } key_act_t;

  // Grid: 1 2 3 A / 4 5 6 B / 7 8 9 C / - 0 + D, indexed by row*4 + column
  localparam key_act_t KEY_ACTION [16] = '{
    ACT_LEVEL, ACT_LEVEL, ACT_LEVEL, ACT_SEL_RED,
    ACT_LEVEL, ACT_LEVEL, ACT_LEVEL, ACT_SEL_GREEN,
    ACT_LEVEL, ACT_LEVEL, ACT_LEVEL, ACT_SEL_BLUE,
    ACT_MINUS, ACT_LEVEL, ACT_PLUS,  ACT_NONE
  };

  // Level loaded by digit keys; key 9 gives full scale
  localparam level_t KEY_LEVEL [16] = '{
    level_t'(11), level_t'(22), level_t'(33), level_t'(0),
    level_t'(44), level_t'(55), level_t'(66), level_t'(0),
    level_t'(77), level_t'(88), level_t'(100), level_t'(0),
    level_t'(0),  level_t'(0),  level_t'(0),  level_t'(0)
  };

endpackage

### sv/krpd_in_if.sv
// ----------------------------------------------------------------------------
// krpd_in_if
// Input channel: key events and PWM slot ticks.
// ----------------------------------------------------------------------------
interface krpd_in_if;
  import krpd_pkg::*;

  logic  valid;
  logic  ready;
  logic  req_type;
  key_t  key_code;

  modport source (output valid, output req_type, output key_code, input ready);
  modport sink   (input valid, input req_type, input key_code, output ready);
endinterface

### sv/krpd_out_if.sv
// ----------------------------------------------------------------------------
// krpd_out_if
// Result channel: channel drive levels, working level and selection.
// ----------------------------------------------------------------------------
interface krpd_out_if;
  import krpd_pkg::*;

  logic      valid;
  logic      ready;
  logic      red_on;
  logic      green_on;
  logic      blue_on;
  level_t    working_level;
  chan_sel_t selected_channel;

  modport source (output valid, output red_on, output green_on, output blue_on,
                  output working_level, output selected_channel, input ready);
  modport sink   (input valid, input red_on, input green_on, input blue_on,
                  input working_level, input selected_channel, output ready);
endinterface

### sv/keypad_rgb_pwm_dimmer_core.sv
// ----------------------------------------------------------------------------
// keypad_rgb_pwm_dimmer_core
// Three-channel LED PWM controller commanded by keypad events.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one word per key press (req_type 0, key_code = row*4+col)
//   or per PWM slot tick (req_type 1). Every word gives one result word on
//   out_ch: the red/green/blue drive for the current slot, the working level
//   and the selected channel after that word.
//   cfg_we/cfg_wdata load step_size, used by the plus and minus keys; write
//   it only while no word is in flight.
//   The result is registered: out_ch.valid rises in the cycle after acceptance;
//   throughput is one word per cycle while out_ch takes each result.
//   While out_ch is stalled the result register holds and in_ch.ready drops
//   until the pending word is taken; a word is accepted in the same cycle
//   that the pending result leaves.
//   Reset clears level, selection, all duties and the slot counter, sets
//   step_size to 1 and empties the output register.
// ----------------------------------------------------------------------------
module keypad_rgb_pwm_dimmer_core #(
  parameter int PWM_SLOTS = krpd_pkg::PWM_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  krpd_in_if.sink               in_ch,
  krpd_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  krpd_pkg::step_t       cfg_wdata
);
  import krpd_pkg::*;

  localparam int SLOT_W = (PWM_SLOTS > 2) ? $clog2(PWM_SLOTS) : 1;

  typedef logic [SLOT_W-1:0] slot_t;

  step_t     step_r;
  level_t    level_r,  level_nxt;
  chan_sel_t sel_r,    sel_nxt;
  level_t    red_r,    red_nxt;
  level_t    green_r,  green_nxt;
  level_t    blue_r,   blue_nxt;
  slot_t     slot_r,   slot_nxt;
  logic      out_valid_r;

  logic      accept;
  key_act_t  act;
  logic [LEVEL_W:0] sum;
  logic [SLOT_W:0]  slot_inc;
  level_t    slot_ext;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign act         = KEY_ACTION[in_ch.key_code];
  assign sum         = {1'b0, level_r} + (LEVEL_W+1)'(step_r);
  assign slot_inc    = {1'b0, slot_r} + (SLOT_W+1)'(1);
  assign slot_ext    = LEVEL_W'(slot_r);

  always_comb begin
    level_nxt = level_r;
    sel_nxt   = sel_r;
    red_nxt   = red_r;
    green_nxt = green_r;
    blue_nxt  = blue_r;
    slot_nxt  = slot_r;
    if (in_ch.req_type) begin
      // advance the slot counter, wrap after the last slot
      if (slot_inc >= (SLOT_W+1)'(PWM_SLOTS)) begin
        slot_nxt = '0;
      end else begin
        slot_nxt = slot_inc[SLOT_W-1:0];
      end
    end else begin
      case (act)
        ACT_LEVEL: begin
          level_nxt = KEY_LEVEL[in_ch.key_code];
        end
        ACT_PLUS: begin
          level_nxt = (sum > (LEVEL_W+1)'(LEVEL_MAX)) ? LEVEL_MAX : sum[LEVEL_W-1:0];
        end
        ACT_MINUS: begin
          level_nxt = (level_r > LEVEL_W'(step_r)) ? level_r - LEVEL_W'(step_r) : '0;
        end
        ACT_SEL_RED: begin
          sel_nxt   = SEL_RED;
          level_nxt = red_r;
        end
        ACT_SEL_GREEN: begin
          sel_nxt   = SEL_GREEN;
          level_nxt = green_r;
        end
        ACT_SEL_BLUE: begin
          sel_nxt   = SEL_BLUE;
          level_nxt = blue_r;
        end
        default: begin
        end
      endcase
      // selected duty follows the level
      case (sel_nxt)
        SEL_RED:   red_nxt   = level_nxt;
        SEL_GREEN: green_nxt = level_nxt;
        SEL_BLUE:  blue_nxt  = level_nxt;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_RESET;
      level_r     <= '0;
      sel_r       <= SEL_NONE;
      red_r       <= '0;
      green_r     <= '0;
      blue_r      <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        step_r <= cfg_wdata;
      end
      if (accept) begin
        level_r     <= level_nxt;
        sel_r       <= sel_nxt;
        red_r       <= red_nxt;
        green_r     <= green_nxt;
        blue_r      <= blue_nxt;
        slot_r      <= slot_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload: current slot against the duties after this word
  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.red_on           <= slot_ext < red_nxt;
      out_ch.green_on         <= slot_ext < green_nxt;
      out_ch.blue_on          <= slot_ext < blue_nxt;
      out_ch.working_level    <= level_nxt;
      out_ch.selected_channel <= sel_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;

endmodule
